// File: rtl/thread_run_queue_scheduler_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef THREAD_RUN_QUEUE_SCHEDULER_MACROS_SVH
`define THREAD_RUN_QUEUE_SCHEDULER_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define TRQS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define TRQS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/trqs_pkg.sv
// Types and constants of the thread run queue scheduler.
package trqs_pkg;

  localparam int unsigned THREADS = 8;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned SLICE_W = 24;
  localparam int unsigned IDENT_W = 32;
  localparam int unsigned CMD_W   = 3;

  localparam logic [SLICE_W-1:0] TIMESLICE_RESET = 24'd10000;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_YIELD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WAIT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_WAKEUP = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd5;

  typedef enum logic [1:0] {
    ST_INVALID = 2'd0,
    ST_RUNNING = 2'd1,
    ST_READY   = 2'd2,
    ST_BLOCKED = 2'd3
  } status_e;

endpackage

// File: rtl/thread_run_queue_scheduler.sv
// Thread scheduler with a circular run queue, an ordered blocked list and a sequencer.
//
// One command beat is taken while the sequencer is idle. Every command passes
// through the execute and finish states; yield, tick, wait and an accepted start
// also pass through dispatch, and wakeup through scan, where the single ident
// comparator walks the blocked list one entry a cycle. The result beat is held
// in an output register, so the next command is accepted while it waits to be taken.
// The timeslice register may be written whenever the block is idle.
`include "thread_run_queue_scheduler_macros.svh"

module thread_run_queue_scheduler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [trqs_pkg::SLICE_W-1:0]        cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [trqs_pkg::CMD_W-1:0]          command_i,
  input  logic [trqs_pkg::SLOT_W-1:0]         thread_id_i,
  input  logic [trqs_pkg::IDENT_W-1:0]        ident_i,
  input  logic [trqs_pkg::SLICE_W-1:0]        timer_value_i,
  input  logic                                timer_wrapped_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                running_valid_o,
  output logic [trqs_pkg::SLOT_W-1:0]         running_thread_o,
  output logic [trqs_pkg::SLICE_W-1:0]        slice_load_o,
  output logic                                woke_any_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DISPATCH,
    S_FIN
  } state_e;

  state_e state_q;

  // Latched command beat.
  logic [trqs_pkg::CMD_W-1:0]   cmd_q;
  logic [trqs_pkg::SLOT_W-1:0]  tid_q;
  logic [trqs_pkg::IDENT_W-1:0] ident_q;
  logic [trqs_pkg::SLICE_W-1:0] tval_q;
  logic                         wrapped_q;

  // Scheduler state.
  logic [trqs_pkg::SLICE_W-1:0] timeslice_q;
  trqs_pkg::status_e            status_q [trqs_pkg::THREADS];
  logic [trqs_pkg::SLICE_W-1:0] slice_q  [trqs_pkg::THREADS];
  logic [trqs_pkg::IDENT_W-1:0] wident_q [trqs_pkg::THREADS];
  logic [trqs_pkg::SLOT_W-1:0]  fifo_q   [trqs_pkg::THREADS];
  logic [trqs_pkg::SLOT_W-1:0]  blist_q  [trqs_pkg::THREADS];
  logic [trqs_pkg::SLOT_W-1:0]  head_q;
  logic [trqs_pkg::CNT_W-1:0]   rcount_q;
  logic [trqs_pkg::CNT_W-1:0]   bcount_q;
  logic [trqs_pkg::SLOT_W-1:0]  cur_q;
  logic                         cur_valid_q;
  logic [trqs_pkg::CNT_W-1:0]   scan_q;
  logic [trqs_pkg::CNT_W-1:0]   keep_q;
  logic                         found_q;

  // Output register.
  logic                         out_valid_q;
  logic                         run_valid_q;
  logic [trqs_pkg::SLOT_W-1:0]  run_thread_q;
  logic [trqs_pkg::SLICE_W-1:0] slice_load_q;
  logic                         woke_q;

  logic                         in_acc;
  logic                         out_free;
  logic [trqs_pkg::SLOT_W-1:0]  tail_idx;
  logic [trqs_pkg::SLOT_W-1:0]  head_slot;
  logic [trqs_pkg::SLOT_W-1:0]  scan_slot;
  logic                         scan_done;
  logic                         ident_hit;
  logic                         short_slice;
  logic                         create_ok;
  logic                         start_ok;
  logic                         requeue;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Queue and scan addressing, and the shared ident comparator.
  assign tail_idx    = head_q + rcount_q[trqs_pkg::SLOT_W-1:0];
  assign head_slot   = fifo_q[head_q];
  assign scan_slot   = blist_q[scan_q[trqs_pkg::SLOT_W-1:0]];
  assign scan_done   = (scan_q == bcount_q);
  assign ident_hit   = (wident_q[scan_slot] == ident_q);
  assign short_slice = wrapped_q ||
                       (tval_q < {8'd0, timeslice_q[trqs_pkg::SLICE_W-1:8]});

  // Command decode on the latched beat.
  assign create_ok = (cmd_q == trqs_pkg::CMD_CREATE) &&
                     (status_q[tid_q] == trqs_pkg::ST_INVALID);
  assign start_ok  = (cmd_q == trqs_pkg::CMD_START) && !cur_valid_q &&
                     (status_q[tid_q] == trqs_pkg::ST_INVALID);
  assign requeue   = ((cmd_q == trqs_pkg::CMD_YIELD) || (cmd_q == trqs_pkg::CMD_TICK)) &&
                     cur_valid_q;

  // Sequencer, control state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      timeslice_q  <= trqs_pkg::TIMESLICE_RESET;
      for (int i = 0; i < trqs_pkg::THREADS; i++) begin
        status_q[i] <= trqs_pkg::ST_INVALID;
        slice_q[i]  <= '0;
      end
      head_q       <= '0;
      rcount_q     <= '0;
      bcount_q     <= '0;
      cur_q        <= '0;
      cur_valid_q  <= 1'b0;
      scan_q       <= '0;
      keep_q       <= '0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      run_valid_q  <= 1'b0;
      run_thread_q <= '0;
      slice_load_q <= '0;
      woke_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeslice_q <= cfg_wdata_i;
      end
      // The finishing state reloads the output register itself.
      if (out_valid_q && !out_stall_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          found_q <= 1'b0;
          scan_q  <= '0;
          keep_q  <= '0;
          state_q <= S_FIN;
          if (create_ok) begin
            status_q[tid_q] <= trqs_pkg::ST_READY;
            slice_q[tid_q]  <= '0;
            rcount_q        <= rcount_q + 1'b1;
          end else if (start_ok) begin
            // Start makes the slot current and yields it straight away.
            status_q[tid_q] <= trqs_pkg::ST_READY;
            slice_q[tid_q]  <= '0;
            rcount_q        <= rcount_q + 1'b1;
            state_q         <= S_DISPATCH;
          end else if (requeue) begin
            status_q[cur_q] <= trqs_pkg::ST_READY;
            slice_q[cur_q]  <= '0;
            rcount_q        <= rcount_q + 1'b1;
            state_q         <= S_DISPATCH;
          end else if ((cmd_q == trqs_pkg::CMD_YIELD) || (cmd_q == trqs_pkg::CMD_TICK)) begin
            state_q <= S_DISPATCH;
          end else if (cmd_q == trqs_pkg::CMD_WAIT) begin
            if (cur_valid_q) begin
              status_q[cur_q] <= trqs_pkg::ST_BLOCKED;
              slice_q[cur_q]  <= short_slice ? '0 : tval_q;
              bcount_q        <= bcount_q + 1'b1;
            end
            state_q <= S_DISPATCH;
          end else if (cmd_q == trqs_pkg::CMD_WAKEUP) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          // One blocked entry per cycle; survivors are packed toward the front.
          if (scan_done) begin
            bcount_q <= keep_q;
            state_q  <= S_FIN;
          end else begin
            scan_q <= scan_q + 1'b1;
            if (ident_hit) begin
              status_q[scan_slot] <= trqs_pkg::ST_READY;
              found_q             <= 1'b1;
              rcount_q            <= rcount_q + 1'b1;
              if (slice_q[scan_slot] != '0) begin
                head_q <= head_q - 1'b1;
              end
            end else begin
              keep_q <= keep_q + 1'b1;
            end
          end
        end
        S_DISPATCH: begin
          if (rcount_q == '0) begin
            cur_valid_q <= 1'b0;
            cur_q       <= '0;
          end else begin
            cur_q                 <= head_slot;
            cur_valid_q           <= 1'b1;
            head_q                <= head_q + 1'b1;
            rcount_q              <= rcount_q - 1'b1;
            status_q[head_slot]   <= trqs_pkg::ST_RUNNING;
            if (slice_q[head_slot] == '0) begin
              slice_q[head_slot] <= timeslice_q;
            end
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            run_valid_q  <= cur_valid_q;
            run_thread_q <= cur_valid_q ? cur_q : '0;
            slice_load_q <= cur_valid_q ? slice_q[cur_q] : '0;
            woke_q       <= found_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Payload stores: command latch, run queue, blocked list and wait idents.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q     <= command_i;
      tid_q     <= thread_id_i;
      ident_q   <= ident_i;
      tval_q    <= timer_value_i;
      wrapped_q <= timer_wrapped_i;
    end
    if (state_q == S_EXEC) begin
      if (create_ok || start_ok) begin
        fifo_q[tail_idx] <= tid_q;
      end else if (requeue) begin
        fifo_q[tail_idx] <= cur_q;
      end else if ((cmd_q == trqs_pkg::CMD_WAIT) && cur_valid_q) begin
        wident_q[cur_q] <= ident_q;
        blist_q[bcount_q[trqs_pkg::SLOT_W-1:0]] <= cur_q;
      end
    end
    if ((state_q == S_SCAN) && !scan_done) begin
      if (ident_hit) begin
        if (slice_q[scan_slot] != '0) begin
          fifo_q[head_q - 1'b1] <= scan_slot;
        end else begin
          fifo_q[tail_idx] <= scan_slot;
        end
      end else begin
        blist_q[keep_q[trqs_pkg::SLOT_W-1:0]] <= scan_slot;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign running_valid_o  = run_valid_q;
  assign running_thread_o = run_thread_q;
  assign slice_load_o     = slice_load_q;
  assign woke_any_o       = woke_q;

  // Between commands the current thread, run queue and blocked list together hold
  // no more threads than there are slots.
  `TRQS_ASSERT_IMPL(a_thread_budget, state_q == S_IDLE,
    ({1'b0, rcount_q} + {1'b0, bcount_q} + {4'd0, cur_valid_q}) <= 5'(trqs_pkg::THREADS),
    "scheduler holds more threads than slots")
  // An accepted beat always starts the sequencer.
  `TRQS_ASSERT_NEXT(a_accept_exec, in_acc, state_q == S_EXEC,
    "accepted command did not start execution")
  // The wakeup scan never runs past the blocked list.
  `TRQS_ASSERT_IMPL(a_scan_bound, state_q == S_SCAN,
    (scan_q <= bcount_q) && (keep_q <= scan_q), "blocked list scan out of range")

endmodule

// File: test/trqs_checker.sv
// Checker that predicts scheduler results from accepted command beats and compares them.
module trqs_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [trqs_pkg::SLICE_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [trqs_pkg::CMD_W-1:0]    command_i,
  input  logic [trqs_pkg::SLOT_W-1:0]   thread_id_i,
  input  logic [trqs_pkg::IDENT_W-1:0]  ident_i,
  input  logic [trqs_pkg::SLICE_W-1:0]  timer_value_i,
  input  logic                          timer_wrapped_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          running_valid_i,
  input  logic [trqs_pkg::SLOT_W-1:0]   running_thread_i,
  input  logic [trqs_pkg::SLICE_W-1:0]  slice_load_i,
  input  logic                          woke_any_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import trqs_pkg::*;

  typedef struct packed {
    logic               run_valid;
    logic [SLOT_W-1:0]  run_slot;
    logic [SLICE_W-1:0] slice;
    logic               woke;
  } sched_result_t;

  // Shadow scheduler state.
  logic [SLICE_W-1:0] slice_len;
  status_e            status [THREADS];
  logic [IDENT_W-1:0] wait_id [THREADS];
  logic [SLICE_W-1:0] slice_left [THREADS];
  logic [SLOT_W-1:0]  run_queue [$];
  logic [SLOT_W-1:0]  blocked [$];
  logic               cur_valid;
  logic [SLOT_W-1:0]  cur_slot;
  sched_result_t      expected_results [$];

  assign pending_o = expected_results.size();

  // Take the run-queue head as the current thread.
  task automatic dispatch_head();
    if (run_queue.size() == 0) begin
      cur_valid = 1'b0;
      cur_slot  = '0;
    end else begin
      cur_slot  = run_queue.pop_front();
      cur_valid = 1'b1;
      status[cur_slot] = ST_RUNNING;
      if (slice_left[cur_slot] == 0) slice_left[cur_slot] = slice_len;
    end
  endtask

  task automatic requeue_current();
    if (cur_valid) begin
      slice_left[cur_slot] = '0;
      status[cur_slot] = ST_READY;
      run_queue.push_back(cur_slot);
    end
    dispatch_head();
  endtask

  task automatic predict_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] tid,
                                 input logic [IDENT_W-1:0] id, input logic [SLICE_W-1:0] tval,
                                 input logic wrapped);
    sched_result_t      res;
    logic               woke;
    logic [SLOT_W-1:0]  kept [$];
    logic [SLOT_W-1:0]  s;
    logic [SLICE_W-1:0] left;
    woke = 1'b0;
    case (cmd)
      CMD_CREATE: begin
        if (status[tid] == ST_INVALID) begin
          status[tid] = ST_READY;
          slice_left[tid] = '0;
          run_queue.push_back(tid);
        end
      end
      CMD_START: begin
        if (!cur_valid && status[tid] == ST_INVALID) begin
          cur_slot = tid;
          cur_valid = 1'b1;
          status[tid] = ST_RUNNING;
          slice_left[tid] = '0;
          requeue_current();
        end
      end
      CMD_YIELD, CMD_TICK: requeue_current();
      CMD_WAIT: begin
        if (cur_valid) begin
          left = tval;
          if (wrapped || tval < slice_len / 256) left = '0;
          slice_left[cur_slot] = left;
          wait_id[cur_slot] = id;
          status[cur_slot] = ST_BLOCKED;
          blocked.push_back(cur_slot);
        end
        dispatch_head();
      end
      CMD_WAKEUP: begin
        foreach (blocked[i]) begin
          s = blocked[i];
          if (wait_id[s] != id) kept.push_back(s);
          else begin
            status[s] = ST_READY;
            if (slice_left[s] != 0) run_queue.push_front(s);
            else run_queue.push_back(s);
            woke = 1'b1;
          end
        end
        blocked = kept;
      end
      default: ;
    endcase
    res.run_valid = cur_valid;
    res.run_slot  = cur_valid ? cur_slot : '0;
    res.slice     = cur_valid ? slice_left[cur_slot] : '0;
    res.woke      = woke;
    expected_results.push_back(res);
  endtask

  // Predict on accepted commands, compare on accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t e;
    if (!rst_ni) begin
      slice_len = TIMESLICE_RESET;
      for (int i = 0; i < THREADS; i++) begin
        status[i] = ST_INVALID;
        wait_id[i] = '0;
        slice_left[i] = '0;
      end
      run_queue.delete();
      blocked.delete();
      expected_results.delete();
      cur_valid = 1'b0;
      cur_slot = '0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o++;
        end else begin
          e = expected_results.pop_front();
          if (running_valid_i !== e.run_valid) begin
            $error("running_valid expected %0d actual %0d", e.run_valid, running_valid_i);
            fail_count_o++;
          end
          if (running_thread_i !== e.run_slot) begin
            $error("running_thread expected %0d actual %0d", e.run_slot, running_thread_i);
            fail_count_o++;
          end
          if (slice_load_i !== e.slice) begin
            $error("slice_load expected %0d actual %0d", e.slice, slice_load_i);
            fail_count_o++;
          end
          if (woke_any_i !== e.woke) begin
            $error("woke_any expected %0d actual %0d", e.woke, woke_any_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_command(command_i, thread_id_i, ident_i, timer_value_i, timer_wrapped_i);
      if (cfg_we_i) slice_len = cfg_wdata_i;
    end
  end
endmodule

// File: test/tb_top.sv
// Testbench top: drives scheduler commands and configuration, and gives the verdict.
module tb_top;
  import trqs_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [SLICE_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [CMD_W-1:0]   command_i = '0;
  logic [SLOT_W-1:0]  thread_id_i = '0;
  logic [IDENT_W-1:0] ident_i = '0;
  logic [SLICE_W-1:0] timer_value_i = '0;
  logic               timer_wrapped_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               running_valid_o;
  logic [SLOT_W-1:0]  running_thread_o;
  logic [SLICE_W-1:0] slice_load_o;
  logic               woke_any_o;
  int                 fail_count;
  int                 pending;
  bit                 quiet_phase = 1'b0;
  bit                 hold_off_req = 1'b0;

  always #5 clk_i = ~clk_i;

  thread_run_queue_scheduler uut (.*);

  trqs_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_i(in_stall_o),
    .command_i, .thread_id_i, .ident_i, .timer_value_i, .timer_wrapped_i,
    .out_valid_i(out_valid_o), .out_stall_i, .running_valid_i(running_valid_o),
    .running_thread_i(running_thread_o), .slice_load_i(slice_load_o),
    .woke_any_i(woke_any_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Result-side stall: random bursts, plus one long hold-off on request.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_off_req = 1'b0;
        @(posedge clk_i);
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        @(posedge clk_i);
      end
    end
  end

  // Offer one command beat and hold it until accepted.
  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] tid,
                          input logic [IDENT_W-1:0] id, input logic [SLICE_W-1:0] tval,
                          input logic wrapped);
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= cmd;
    thread_id_i     <= tid;
    ident_i         <= id;
    timer_value_i   <= tval;
    timer_wrapped_i <= wrapped;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_slice(input logic [SLICE_W-1:0] v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CMD_W-1:0] CMD_CMD_pad();
    return CMD_W'($urandom_range(6, 7));
  endfunction

  // Random command drawn from a small ident pool so waits and wakeups meet.
  task automatic random_cmd();
    logic [CMD_W-1:0]   cmd;
    logic [IDENT_W-1:0] id;
    logic [SLICE_W-1:0] tval;
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 12) cmd = CMD_CREATE;
    else if (r < 20) cmd = CMD_START;
    else if (r < 38) cmd = CMD_YIELD;
    else if (r < 60) cmd = CMD_WAIT;
    else if (r < 82) cmd = CMD_WAKEUP;
    else if (r < 97) cmd = CMD_TICK;
    else cmd = CMD_CMD_pad();
    id = ($urandom_range(0, 9) == 0) ? $urandom() : IDENT_W'($urandom_range(0, 3));
    tval = ($urandom_range(0, 1) != 0) ? SLICE_W'($urandom()) : SLICE_W'($urandom_range(0, 200));
    send_cmd(cmd, CMD_W'($urandom_range(0, 7)), id, tval, $urandom_range(0, 3) == 0);
  endtask

  initial begin
    logic [SLICE_W-1:0] slices [4];
    slices[0] = '1;
    slices[1] = 24'd1;
    slices[2] = 24'd0;
    slices[3] = 24'd700;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: idle commands, refusals, wait edge cases, wakeup order.
    send_cmd(CMD_YIELD, 0, 0, 0, 0);
    send_cmd(CMD_WAIT, 0, 32'hFFFF_FFFF, '1, 0);
    send_cmd(CMD_WAKEUP, 0, 0, 0, 0);
    send_cmd(CMD_START, 3'd7, 0, 0, 0);
    send_cmd(CMD_START, 3'd0, 0, 0, 0);
    send_cmd(CMD_CREATE, 3'd7, 0, 0, 0);
    for (int t = 0; t < 6; t++) send_cmd(CMD_CREATE, SLOT_W'(t), 0, 0, 0);
    send_cmd(CMD_WAIT, 0, 32'hFFFF_FFFF, '1, 0);
    send_cmd(CMD_WAIT, 0, 32'hFFFF_FFFF, 24'd5000, 1);
    send_cmd(CMD_WAIT, 0, 32'd0, 24'd38, 0);
    send_cmd(CMD_WAIT, 0, 32'd0, 24'd39, 0);
    send_cmd(CMD_TICK, 0, 0, 0, 0);
    send_cmd(CMD_WAKEUP, 0, 32'hFFFF_FFFF, 0, 0);
    send_cmd(CMD_WAKEUP, 0, 32'd0, 0, 0);
    send_cmd(CMD_WAKEUP, 0, 32'd0, 0, 0);
    send_cmd(3'd6, 0, 0, 0, 0);
    send_cmd(3'd7, 3'd7, '1, '1, 1);
    send_cmd(CMD_YIELD, 0, 0, 0, 0);

    // Random phases across several timeslice settings.
    for (int p = 0; p < 4; p++) begin
      write_slice(slices[p]);
      for (int i = 0; i < 300; i++) begin
        if (p == 1 && i == 100) begin
          hold_off_req = 1'b1;
          for (int k = 0; k < 20; k++) random_cmd();
        end
        if (p == 2 && i == 150) drain_results();
        random_cmd();
      end
    end
    write_slice(TIMESLICE_RESET);
    quiet_phase = 1'b1;
    for (int i = 0; i < 300; i++) random_cmd();
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
